>>> rtl/ldtc_pkg.sv
package ldtc_pkg;

    localparam logic [16:0] THR_FULL = 17'h10000;

    localparam logic [1:0] CLAMP_NONE = 2'd0;
    localparam logic [1:0] CLAMP_ZERO = 2'd1;
    localparam logic [1:0] CLAMP_FULL = 2'd2;

    localparam logic [2:0] REG_LAW_MODE   = 3'd0;
    localparam logic [2:0] REG_PLANET_RAD = 3'd1;
    localparam logic [2:0] REG_GM_THRUST  = 3'd2;
    localparam logic [2:0] REG_DRY_MASS   = 3'd3;
    localparam logic [2:0] REG_FUEL_MASS  = 3'd4;
    localparam logic [2:0] REG_GAIN_PROP  = 3'd5;
    localparam logic [2:0] REG_GAIN_SEC   = 3'd6;
    localparam logic [2:0] REG_SET_POINT  = 3'd7;

    // 5000 m in Q24.8, and (200 m/s)^2 in Q.32
    localparam logic signed [33:0] CHUTE_ALT = 34'sd1280000;
    localparam logic [63:0]        CHUTE_V2  = 64'd171798691840000;

    localparam logic [60:0] DELTA_CAP = 61'h1000_0000_0000_0000;

    localparam logic [6:0] ROOT_STEPS = 7'd32;
    localparam logic [6:0] VR_STEPS   = 7'd64;
    localparam logic [6:0] DLT_STEPS  = 7'd60;

    typedef struct packed {
        logic        law_mode;
        logic [30:0] planet_radius;
        logic [39:0] gm_over_max_thrust;
        logic [23:0] dry_mass;
        logic [23:0] full_fuel_mass;
        logic [23:0] gain_prop;
        logic [23:0] gain_second;
        logic [31:0] set_point;
    } t_cfg;

    typedef struct packed {
        logic        start;
        logic        is_root;
        logic [63:0] rem0;
        logic [63:0] num;
        logic [63:0] den;
        logic [6:0]  steps;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [63:0] quo;
    } t_div_rsp;

endpackage

>>> rtl/ldtc_mul.sv
module ldtc_mul (
    input  logic        i_clk,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic [63:0] o_prod
);

    logic [63:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= 64'(i_a) * 64'(i_b);
    end

    assign o_prod = r_prod;

endmodule

>>> rtl/ldtc_div.sv
module ldtc_div import ldtc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [6:0]  r_cnt;
    logic        r_done;
    logic        r_root;
    logic [63:0] r_rem;
    logic [63:0] r_num;
    logic [63:0] r_den;
    logic [63:0] r_quo;

    logic [64:0] rem_sh;
    logic [64:0] trial;
    logic [64:0] diff;
    logic        fits;

    // one restoring step: a quotient bit for division, a root bit for square root
    always_comb begin
        if (r_root) begin
            rem_sh = {r_rem[62:0], r_num[63:62]};
            trial  = {1'b0, r_quo[61:0], 2'b01};
        end else begin
            rem_sh = {r_rem, r_num[63]};
            trial  = {1'b0, r_den};
        end
        diff = rem_sh - trial;
        fits = (rem_sh >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt <= i_req.steps;
            end else if (r_cnt != 7'd0) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_root <= i_req.is_root;
            r_rem  <= i_req.rem0;
            r_num  <= i_req.num;
            r_den  <= i_req.den;
            r_quo  <= '0;
        end else if (r_cnt != 7'd0) begin
            r_rem <= fits ? diff[63:0] : rem_sh[63:0];
            r_quo <= {r_quo[62:0], fits};
            r_num <= r_root ? {r_num[61:0], 2'b00} : {r_num[62:0], 1'b0};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

>>> rtl/ldtc_cfg.sv
module ldtc_cfg import ldtc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output t_cfg        o_cfg
);

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.law_mode           <= 1'b1;
            r_cfg.planet_radius      <= '0;
            r_cfg.gm_over_max_thrust <= '0;
            r_cfg.dry_mass           <= '0;
            r_cfg.full_fuel_mass     <= '0;
            r_cfg.gain_prop          <= 24'd65536;
            r_cfg.gain_second        <= '0;
            r_cfg.set_point          <= 32'd128000;
        end else if (wr_en) begin
            case (idx)
                REG_LAW_MODE:   r_cfg.law_mode           <= pwdata[0];
                REG_PLANET_RAD: r_cfg.planet_radius      <= pwdata[30:0];
                REG_GM_THRUST:  r_cfg.gm_over_max_thrust <= pwdata[39:0];
                REG_DRY_MASS:   r_cfg.dry_mass           <= pwdata[23:0];
                REG_FUEL_MASS:  r_cfg.full_fuel_mass     <= pwdata[23:0];
                REG_GAIN_PROP:  r_cfg.gain_prop          <= pwdata[23:0];
                REG_GAIN_SEC:   r_cfg.gain_second        <= pwdata[23:0];
                REG_SET_POINT:  r_cfg.set_point          <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_LAW_MODE:   prdata = {63'b0, r_cfg.law_mode};
            REG_PLANET_RAD: prdata = {33'b0, r_cfg.planet_radius};
            REG_GM_THRUST:  prdata = {24'b0, r_cfg.gm_over_max_thrust};
            REG_DRY_MASS:   prdata = {40'b0, r_cfg.dry_mass};
            REG_FUEL_MASS:  prdata = {40'b0, r_cfg.full_fuel_mass};
            REG_GAIN_PROP:  prdata = {40'b0, r_cfg.gain_prop};
            REG_GAIN_SEC:   prdata = {40'b0, r_cfg.gain_second};
            REG_SET_POINT:  prdata = {{32{r_cfg.set_point[31]}}, r_cfg.set_point};
            default:        prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

>>> rtl/lander_descent_throttle_controller.sv
// One item at a time: a new item is taken only in S_IDLE, after the last result
//   is loaded into the output register at S_OUT, which waits while a held result is
//   not taken. One divide/root unit does the root, radial-speed and bias passes.
// Reset (i_rst_n low at a clock edge): sequencer idle, output empty, parachute flag
//   cleared, configuration registers back to their defaults.
module lander_descent_throttle_controller import ldtc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // pos_x[31:0] pos_y[63:32] pos_z[95:64] vel_x[127:96] vel_y[159:128]
    // vel_z[191:160] fuel_level[208:192], zero fill above
    input  logic [215:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // throttle_cmd[16:0] clamp_state[18:17] chute_deploy[19], zero fill above
    output logic [23:0]  m_axis_tdata,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [5:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    // Sequencer steps. A multiply issued in one step is consumed in the next.
    localparam logic [4:0] S_P0     = 5'd0;   // |x|^2 terms of the position
    localparam logic [4:0] S_P1     = 5'd1;
    localparam logic [4:0] S_P2     = 5'd2;
    localparam logic [4:0] S_V0     = 5'd3;   // |v|^2 terms
    localparam logic [4:0] S_V1     = 5'd4;
    localparam logic [4:0] S_V2     = 5'd5;
    localparam logic [4:0] S_D0     = 5'd6;   // dot product terms
    localparam logic [4:0] S_D1     = 5'd7;
    localparam logic [4:0] S_D2     = 5'd8;
    localparam logic [4:0] S_FUEL   = 5'd9;   // fuel share of the mass
    localparam logic [4:0] S_MASS   = 5'd10;  // mass done, launch square root
    localparam logic [4:0] S_ROOT   = 5'd11;  // wait on root; gm low product
    localparam logic [4:0] S_GM_HI  = 5'd12;
    localparam logic [4:0] S_GM_ADD = 5'd13;  // launch radial-speed divide
    localparam logic [4:0] S_VR     = 5'd14;
    localparam logic [4:0] S_DLT_GO = 5'd15;  // launch hover-bias divide
    localparam logic [4:0] S_DLT    = 5'd16;
    localparam logic [4:0] S_LAW_A  = 5'd17;  // first gain product
    localparam logic [4:0] S_A_LO   = 5'd18;
    localparam logic [4:0] S_A_HI   = 5'd19;
    localparam logic [4:0] S_A_ADD  = 5'd20;
    localparam logic [4:0] S_A_END  = 5'd21;
    localparam logic [4:0] S_LAW_B  = 5'd22;  // second gain product
    localparam logic [4:0] S_B_LO   = 5'd23;
    localparam logic [4:0] S_B_HI   = 5'd24;
    localparam logic [4:0] S_B_ADD  = 5'd25;
    localparam logic [4:0] S_SUM    = 5'd26;  // bias plus correction, chute test
    localparam logic [4:0] S_OUT    = 5'd27;  // clamp and hand to the output register
    localparam logic [4:0] S_IDLE   = 5'd31;

    t_cfg     cfg;
    t_div_req div_req;
    t_div_rsp div_rsp;

    logic [4:0]  r_step;
    logic [4:0]  n_step;

    logic [31:0] r_pos [3];
    logic [31:0] r_vel [3];
    logic [16:0] r_fuel;

    logic [63:0] r_r2;
    logic [63:0] r_v2;
    logic [63:0] r_dot_pos;
    logic [63:0] r_dot_neg;
    logic [25:0] r_mass;
    logic [31:0] r_rad;
    logic [65:0] r_gm;
    logic signed [63:0] r_vr;
    logic        r_cap;
    logic [60:0] r_delta;
    logic signed [63:0] r_x;
    logic [23:0] r_g;
    logic [95:0] r_acc;
    logic signed [63:0] r_t1;
    logic signed [63:0] r_s;
    logic        r_chute;
    logic        r_out_valid;
    logic [19:0] r_out_data;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] prod;

    logic [31:0] pmag [3];
    logic [31:0] vmag [3];
    logic [63:0] xmag;
    logic        dot_neg;
    logic [63:0] dot_mag;
    logic signed [33:0] alt;
    logic signed [63:0] alt64;
    logic signed [63:0] sp64;
    logic signed [63:0] sp_q16;
    logic signed [63:0] scaled_a;
    logic signed [63:0] scaled_b;
    logic signed [63:0] p_corr;
    logic [16:0] fuel_in;
    logic        dsign;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        mag32 = v[31] ? (~v + 32'd1) : v;
    endfunction

    ldtc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    ldtc_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    ldtc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            pmag[k] = mag32(r_pos[k]);
            vmag[k] = mag32(r_vel[k]);
        end
    end

    assign xmag    = r_x[63] ? 64'(-r_x) : 64'(r_x);
    assign dot_neg = r_dot_neg > r_dot_pos;
    assign dot_mag = dot_neg ? (r_dot_neg - r_dot_pos) : (r_dot_pos - r_dot_neg);
    assign alt     = {2'b00, r_rad} - {3'b000, cfg.planet_radius};
    assign alt64   = {{30{alt[33]}}, alt};
    assign sp64    = {{32{cfg.set_point[31]}}, cfg.set_point};
    assign sp_q16  = {{24{cfg.set_point[31]}}, cfg.set_point, 8'b0};
    assign scaled_a = r_x[63] ? -$signed(r_acc[71:8]) : $signed(r_acc[71:8]);
    assign scaled_b = r_x[63] ? -$signed(r_acc[79:16]) : $signed(r_acc[79:16]);
    assign p_corr   = cfg.law_mode ? (r_t1 + scaled_b) : -scaled_b;

    // Clamp fuel above a full tank
    assign fuel_in = (s_axis_tdata[208:192] > THR_FULL) ? THR_FULL : s_axis_tdata[208:192];

    // Sign of the dot product term whose magnitude arrives this step
    always_comb begin
        case (r_step)
            S_D1:    dsign = r_pos[0][31] ^ r_vel[0][31];
            S_D2:    dsign = r_pos[1][31] ^ r_vel[1][31];
            default: dsign = r_pos[2][31] ^ r_vel[2][31];
        endcase
    end

    // Operand select for the shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (r_step)
            S_P0: begin mul_a = pmag[0]; mul_b = pmag[0]; end
            S_P1: begin mul_a = pmag[1]; mul_b = pmag[1]; end
            S_P2: begin mul_a = pmag[2]; mul_b = pmag[2]; end
            S_V0: begin mul_a = vmag[0]; mul_b = vmag[0]; end
            S_V1: begin mul_a = vmag[1]; mul_b = vmag[1]; end
            S_V2: begin mul_a = vmag[2]; mul_b = vmag[2]; end
            S_D0: begin mul_a = pmag[0]; mul_b = vmag[0]; end
            S_D1: begin mul_a = pmag[1]; mul_b = vmag[1]; end
            S_D2: begin mul_a = pmag[2]; mul_b = vmag[2]; end
            S_FUEL: begin
                mul_a = {15'b0, r_fuel};
                mul_b = {8'b0, cfg.full_fuel_mass};
            end
            S_ROOT: begin
                mul_a = cfg.gm_over_max_thrust[31:0];
                mul_b = {6'b0, r_mass};
            end
            S_GM_HI: begin
                mul_a = {24'b0, cfg.gm_over_max_thrust[39:32]};
                mul_b = {6'b0, r_mass};
            end
            S_A_LO, S_B_LO: begin
                mul_a = xmag[31:0];
                mul_b = {8'b0, r_g};
            end
            S_A_HI, S_B_HI: begin
                mul_a = xmag[63:32];
                mul_b = {8'b0, r_g};
            end
            default: ;
        endcase
    end

    // Launch requests for the shared divide/root unit
    always_comb begin
        div_req.start   = 1'b0;
        div_req.is_root = 1'b0;
        div_req.rem0    = '0;
        div_req.num     = '0;
        div_req.den     = '0;
        div_req.steps   = ROOT_STEPS;
        case (r_step)
            S_MASS: begin
                div_req.start   = 1'b1;
                div_req.is_root = 1'b1;
                div_req.num     = r_r2;
            end
            S_GM_ADD: begin
                div_req.start = 1'b1;
                div_req.num   = dot_mag;
                div_req.den   = {32'b0, r_rad};
                div_req.steps = VR_STEPS;
            end
            S_DLT_GO: begin
                // numerator is r_gm shifted up by 24; top 30 bits seed the remainder
                div_req.start = 1'b1;
                div_req.rem0  = {34'b0, r_gm[65:36]};
                div_req.num   = {r_gm[35:0], 28'b0};
                div_req.den   = r_r2;
                div_req.steps = DLT_STEPS;
            end
            default: ;
        endcase
    end

    always_comb begin
        case (r_step)
            S_IDLE:              n_step = s_axis_tvalid ? S_P0 : S_IDLE;
            S_ROOT, S_VR, S_DLT: n_step = div_rsp.done ? (r_step + 5'd1) : r_step;
            S_OUT:               n_step = (!r_out_valid || m_axis_tready) ? S_IDLE : S_OUT;
            default:             n_step = r_step + 5'd1;
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= S_IDLE;
            r_chute     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_step <= n_step;
            if (r_step == S_SUM && !cfg.law_mode && alt <= CHUTE_ALT && r_v2 <= CHUTE_V2) begin
                r_chute <= 1'b1;
            end
            // load a new result, else drop the one just taken
            if (r_step == S_OUT && (!r_out_valid || m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath
    always_ff @(posedge i_clk) begin
        case (r_step)
            S_IDLE: begin
                // capture the item
                r_pos[0] <= s_axis_tdata[31:0];
                r_pos[1] <= s_axis_tdata[63:32];
                r_pos[2] <= s_axis_tdata[95:64];
                r_vel[0] <= s_axis_tdata[127:96];
                r_vel[1] <= s_axis_tdata[159:128];
                r_vel[2] <= s_axis_tdata[191:160];
                r_fuel   <= fuel_in;
            end
            S_P1:          r_r2 <= prod;
            S_P2, S_V0:    r_r2 <= r_r2 + prod;
            S_V1:          r_v2 <= prod;
            S_V2, S_D0:    r_v2 <= r_v2 + prod;
            S_D1: begin
                r_dot_pos <= dsign ? 64'd0 : prod;
                r_dot_neg <= dsign ? prod : 64'd0;
            end
            S_D2, S_FUEL: begin
                if (dsign) r_dot_neg <= r_dot_neg + prod;
                else       r_dot_pos <= r_dot_pos + prod;
            end
            S_MASS:  r_mass <= {2'b00, cfg.dry_mass} + {1'b0, prod[40:16]};
            S_ROOT:  r_rad  <= div_rsp.quo[31:0];
            S_GM_HI: r_gm   <= {2'b00, prod};
            S_GM_ADD: r_gm  <= r_gm + {prod[33:0], 32'b0};
            S_VR: begin
                if (r_rad == 32'd0)  r_vr <= '0;
                else if (dot_neg)    r_vr <= -$signed(div_rsp.quo);
                else                 r_vr <= $signed(div_rsp.quo);
            end
            S_DLT_GO: r_cap <= ({34'b0, r_gm[65:36]} >= r_r2);
            S_DLT:    r_delta <= r_cap ? DELTA_CAP : {1'b0, div_rsp.quo[59:0]};
            S_LAW_A: begin
                r_x <= cfg.law_mode ? (sp64 - alt64) : alt64;
                r_g <= cfg.law_mode ? cfg.gain_prop : cfg.gain_second;
            end
            S_A_HI, S_B_HI:   r_acc <= {32'b0, prod};
            S_A_ADD, S_B_ADD: r_acc <= r_acc + {prod, 32'b0};
            S_A_END:          r_t1  <= scaled_a;
            S_LAW_B: begin
                r_x <= cfg.law_mode ? -r_vr : (sp_q16 + r_t1 + r_vr);
                r_g <= cfg.law_mode ? cfg.gain_second : cfg.gain_prop;
            end
            S_SUM: r_s <= $signed({3'b000, r_delta}) + p_corr;
            S_OUT: begin
                if (!r_out_valid || m_axis_tready) begin
                    if (r_s <= 64'sd0) begin
                        r_out_data <= {r_chute, CLAMP_ZERO, 17'd0};
                    end else if (r_s >= 64'sd65536) begin
                        r_out_data <= {r_chute, CLAMP_FULL, THR_FULL};
                    end else begin
                        r_out_data <= {r_chute, CLAMP_NONE, r_s[16:0]};
                    end
                end
            end
            default: ;
        endcase
    end

    assign s_axis_tready = (r_step == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_out_data};

    // Throttle value agrees with the clamp code
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tdata[18:17] == CLAMP_ZERO && m_axis_tdata[16:0] == 17'd0) ||
            (m_axis_tdata[18:17] == CLAMP_FULL && m_axis_tdata[16:0] == THR_FULL) ||
            (m_axis_tdata[18:17] == CLAMP_NONE && m_axis_tdata[16:0] != 17'd0 &&
             m_axis_tdata[16:0] < THR_FULL))
        else $error("throttle and clamp code disagree");

    // Parachute flag never drops outside reset
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> !$fell(r_chute))
        else $error("parachute flag cleared");

    // A new result appears only from the final step
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(r_out_valid) |-> $past(r_step) == S_OUT)
        else $error("result loaded outside final step");

    // The divide/root unit is launched only when the sequencer sits at a launch step
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_req.start |=> (r_step == S_ROOT || r_step == S_VR || r_step == S_DLT))
        else $error("divide unit launched out of order");

endmodule

>>> tb/testbench.sv
module testbench import ldtc_pkg::*; ();

    // One input item: position Q24.8, velocity Q16.16, fuel fraction Q1.16
    typedef struct {
        logic signed [31:0] px, py, pz;
        logic signed [31:0] vx, vy, vz;
        logic [16:0]        fuel;
    } t_state_vec;

    typedef struct {
        logic [16:0] thr;
        logic [1:0]  clamp;
        logic        chute;
    } t_throttle;

    typedef struct {
        t_state_vec in;
        logic       typed;
        t_throttle  want;
    } t_dir_row;

    localparam int IDLE_LIMIT  = 6000;
    localparam int DRAIN_WAIT  = 200;
    localparam int LONG_HOLD   = 900;
    localparam logic [63:0] MAG_LIMIT = 64'h4000_0000_0000_0000;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    // pos_x pos_y pos_z vel_x vel_y vel_z fuel_level, zero fill above
    logic [215:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // throttle_cmd[16:0] clamp_state[18:17] chute_deploy[19], zero fill above
    logic [23:0]  m_axis_tdata;
    logic         psel, penable, pwrite, pready;
    logic [5:0]   paddr;
    logic [63:0]  pwdata, prdata;

    t_cfg      cfg_shadow;
    logic      chute_shadow;
    t_throttle pending_cmds[$];
    int        fail_count;
    int        idle_cycles;
    bit        hold_req;
    bit        calm;
    logic [30:0] phase_radius;

    lander_descent_throttle_controller dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Throttle predictor
    // ------------------------------------------------------------------
    function automatic logic [63:0] int_root(logic [63:0] x);
        logic [63:0] res, b;
        res = 64'd0;
        b = 64'h4000_0000_0000_0000;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // x * g / 2^sh, truncated toward zero, magnitude capped at 2^62
    function automatic longint gain_mul(longint x, logic [23:0] g, int sh);
        logic [127:0] prod;
        logic [127:0] mg;
        logic [63:0]  m;
        mg = {64'd0, (x < 0) ? 64'(-x) : 64'(x)};
        prod = (mg * {104'd0, g}) >> sh;
        m = (prod > {64'd0, MAG_LIMIT}) ? MAG_LIMIT : prod[63:0];
        return (x < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic t_throttle predict_throttle(t_state_vec it);
        longint       p[3], v[3], d, alt, vr, pc, e, s;
        logic [63:0]  r2, v2, pos_sum, neg_sum, rad, fuel, mass, delta;
        logic [127:0] num, quo;
        t_throttle    o;
        p[0] = it.px; p[1] = it.py; p[2] = it.pz;
        v[0] = it.vx; v[1] = it.vy; v[2] = it.vz;
        r2 = 0; v2 = 0; pos_sum = 0; neg_sum = 0; vr = 0;
        for (int k = 0; k < 3; k++) begin
            r2 += 64'(p[k] * p[k]);
            v2 += 64'(v[k] * v[k]);
            d = p[k] * v[k];
            if (d < 0) neg_sum += 64'(-d);
            else pos_sum += 64'(d);
        end
        rad = int_root(r2);
        alt = longint'(rad) - longint'({33'd0, cfg_shadow.planet_radius});
        if (rad != 0) begin
            if (pos_sum >= neg_sum) vr = longint'((pos_sum - neg_sum) / rad);
            else vr = -longint'((neg_sum - pos_sum) / rad);
        end
        fuel = {47'd0, it.fuel};
        if (fuel > 64'd65536) fuel = 64'd65536;
        mass = {40'd0, cfg_shadow.dry_mass} + ((fuel * {40'd0, cfg_shadow.full_fuel_mass}) >> 16);
        num = ({88'd0, cfg_shadow.gm_over_max_thrust} * {64'd0, mass}) << 24;
        if (r2 == 0) begin
            delta = {3'd0, DELTA_CAP};
        end else begin
            quo = num / {64'd0, r2};
            delta = (quo >= {67'd0, DELTA_CAP}) ? {3'd0, DELTA_CAP} : quo[63:0];
        end
        if (cfg_shadow.law_mode == 1'b0) begin
            e = longint'(signed'(cfg_shadow.set_point)) * 256
                + gain_mul(alt, cfg_shadow.gain_second, 8) + vr;
            pc = -gain_mul(e, cfg_shadow.gain_prop, 16);
            // parachute latches on low and slow
            if (alt <= longint'(CHUTE_ALT) && v2 <= CHUTE_V2) chute_shadow = 1'b1;
        end else begin
            pc = gain_mul(longint'(signed'(cfg_shadow.set_point)) - alt,
                          cfg_shadow.gain_prop, 8)
                 + gain_mul(-vr, cfg_shadow.gain_second, 16);
        end
        s = longint'(delta) + pc;
        if (s <= 0) begin
            o.thr = 17'd0; o.clamp = CLAMP_ZERO;
        end else if (s >= 65536) begin
            o.thr = THR_FULL; o.clamp = CLAMP_FULL;
        end else begin
            o.thr = 17'(s); o.clamp = CLAMP_NONE;
        end
        o.chute = chute_shadow;
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Register access and stimulus
    // ------------------------------------------------------------------
    task automatic reg_write(logic [2:0] idx, logic [63:0] val);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 3'b000}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0;
        case (idx)
            REG_LAW_MODE:   cfg_shadow.law_mode = val[0];
            REG_PLANET_RAD: cfg_shadow.planet_radius = val[30:0];
            REG_GM_THRUST:  cfg_shadow.gm_over_max_thrust = val[39:0];
            REG_DRY_MASS:   cfg_shadow.dry_mass = val[23:0];
            REG_FUEL_MASS:  cfg_shadow.full_fuel_mass = val[23:0];
            REG_GAIN_PROP:  cfg_shadow.gain_prop = val[23:0];
            REG_GAIN_SEC:   cfg_shadow.gain_second = val[23:0];
            default:        cfg_shadow.set_point = val[31:0];
        endcase
    endtask

    task automatic wait_drained();
        while (pending_cmds.size() != 0) @(posedge i_clk);
    endtask

    // Load a whole register set once the block has gone quiet
    task automatic load_profile(logic mode, logic [30:0] rad, logic [39:0] gm,
                                logic [23:0] dry, logic [23:0] ffm, logic [23:0] gp,
                                logic [23:0] gs, logic [31:0] sp);
        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        reg_write(REG_LAW_MODE, {63'd0, mode});
        reg_write(REG_PLANET_RAD, {33'd0, rad});
        reg_write(REG_GM_THRUST, {24'd0, gm});
        reg_write(REG_DRY_MASS, {40'd0, dry});
        reg_write(REG_FUEL_MASS, {40'd0, ffm});
        reg_write(REG_GAIN_PROP, {40'd0, gp});
        reg_write(REG_GAIN_SEC, {40'd0, gs});
        reg_write(REG_SET_POINT, {32'd0, sp});
        phase_radius = rad;
    endtask

    // Offer one item, hold it until taken, then maybe drop valid for a burst
    task automatic send_item(t_state_vec it, logic typed, t_throttle want);
        t_throttle got;
        s_axis_tdata <= {7'd0, it.fuel, it.vz, it.vy, it.vx, it.pz, it.py, it.px};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        got = predict_throttle(it);
        pending_cmds.push_back(typed ? want : got);
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    function automatic t_state_vec rand_item();
        t_state_vec it;
        logic [31:0] radial, side1, side2;
        int axis;
        if ($urandom_range(0, 4) == 0) begin
            it.px = $urandom; it.py = $urandom; it.pz = $urandom;
            it.vx = $urandom; it.vy = $urandom; it.vz = $urandom;
            it.fuel = 17'($urandom);
            return it;
        end
        // near-surface approach: mostly along one axis, altitude up to 20 km
        radial = {1'b0, phase_radius} + 32'($urandom_range(0, 20000) * 256);
        if ($urandom_range(0, 1)) radial = -radial;
        side1 = 32'($urandom_range(0, 262144)) - 32'd131072;
        side2 = 32'($urandom_range(0, 262144)) - 32'd131072;
        axis = $urandom_range(0, 2);
        it.px = (axis == 0) ? radial : side1;
        it.py = (axis == 1) ? radial : (axis == 0 ? side1 : side2);
        it.pz = (axis == 2) ? radial : side2;
        it.vx = 32'($urandom_range(0, 39321600)) - 32'd19660800;
        it.vy = 32'($urandom_range(0, 39321600)) - 32'd19660800;
        it.vz = 32'($urandom_range(0, 39321600)) - 32'd19660800;
        it.fuel = 17'($urandom_range(0, 65536));
        return it;
    endfunction

    task automatic run_random(int count, int hold_at, int pause_at);
        t_throttle none;
        none = '{default: '0};
        for (int n = 0; n < count; n++) begin
            if (n == hold_at) hold_req = 1'b1;
            if (n == pause_at) begin
                s_axis_tvalid <= 1'b0;
                wait_drained();
            end
            send_item(rand_item(), 1'b0, none);
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker: compare each accepted item with the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_throttle want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_cmds.size() == 0) begin
                $display("%0t: unexpected result %h", $time, m_axis_tdata);
                fail_count++;
            end else begin
                want = pending_cmds.pop_front();
                if (m_axis_tdata[16:0] !== want.thr) begin
                    $display("%0t: throttle_cmd expected %0d actual %0d",
                             $time, want.thr, m_axis_tdata[16:0]);
                    fail_count++;
                end
                if (m_axis_tdata[18:17] !== want.clamp) begin
                    $display("%0t: clamp_state expected %0d actual %0d",
                             $time, want.clamp, m_axis_tdata[18:17]);
                    fail_count++;
                end
                if (m_axis_tdata[19] !== want.chute) begin
                    $display("%0t: chute_deploy expected %0d actual %0d",
                             $time, want.chute, m_axis_tdata[19]);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: count cycles in which nothing moves on any port
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: random ready bursts, one long hold-off on request
    initial begin
        bit held;
        held = 1'b0;
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !held) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end else if (calm || $urandom_range(0, 1)) begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 20) - 1) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 9) - 1) @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        t_dir_row  dir_rows[$];
        t_state_vec z;
        t_throttle  full_cmd, none;
        hold_req = 1'b0; calm = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0; s_axis_tdata = '0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        cfg_shadow = '{law_mode: 1'b1, planet_radius: '0, gm_over_max_thrust: '0,
                       dry_mass: '0, full_fuel_mass: '0, gain_prop: 24'd65536,
                       gain_second: '0, set_point: 32'd128000};
        chute_shadow = 1'b0;
        phase_radius = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        z = '{default: '0};
        full_cmd = '{thr: THR_FULL, clamp: CLAMP_FULL, chute: 1'b0};
        none = '{default: '0};
        // Position at origin saturates the bias, so full throttle whatever else
        dir_rows.push_back('{z, 1'b1, full_cmd});
        dir_rows.push_back('{'{0, 0, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                               17'h1ffff}, 1'b1, full_cmd});
        dir_rows.push_back('{'{32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                               32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 17'h10000},
                             1'b0, none});
        dir_rows.push_back('{'{32'h80000000, 32'h80000000, 32'h80000000,
                               32'h80000000, 32'h80000000, 32'h80000000, 17'h0},
                             1'b0, none});
        dir_rows.push_back('{'{32'h80000000, 32'h7fffffff, 0,
                               32'h7fffffff, 32'h80000000, 0, 17'h1ffff}, 1'b0, none});
        dir_rows.push_back('{'{1, 0, 0, 0, 0, 0, 17'h10001}, 1'b0, none});
        dir_rows.push_back('{'{0, -1, 0, 0, 32'hffff0000, 0, 17'h8000}, 1'b0, none});
        dir_rows.push_back('{'{0, 0, 128000, 0, 0, 0, 17'h0}, 1'b0, none});
        dir_rows.push_back('{'{0, 0, 32'sd256000, 0, 0, 32'sd655360, 17'h10000},
                             1'b0, none});
        foreach (dir_rows[i]) send_item(dir_rows[i].in, dir_rows[i].typed, dir_rows[i].want);
        run_random(40, -1, -1);

        // Descent-rate law, Mars-sized planet; receiver holds off midway
        load_profile(1'b0, 31'd866816000, 40'd1000000000, 24'd25600, 24'd51200,
                     24'h008000, 24'h000100, 32'd0);
        // Low-altitude, low-speed items in this law drive the parachute
        dir_rows.delete();
        dir_rows.push_back('{'{32'sd867072000, 0, 0, 32'sd655360, 0, 0, 17'h10000},
                             1'b0, none});
        dir_rows.push_back('{'{32'sd868096000, 0, 0, 0, 32'sd13107200, 0, 17'h4000},
                             1'b0, none});
        foreach (dir_rows[i]) send_item(dir_rows[i].in, dir_rows[i].typed, dir_rows[i].want);
        run_random(200, 80, -1);

        // Altitude-hold law; the sender waits out every result midway
        load_profile(1'b1, 31'd866816000, 40'd1000000000, 24'd25600, 24'd51200,
                     24'h000040, 24'h010000, 32'd128000);
        run_random(180, -1, 90);

        // Every register at its top, most negative set point
        load_profile(1'b1, 31'h7fffffff, 40'hff_ffff_ffff, 24'hffffff, 24'hffffff,
                     24'hffffff, 24'hffffff, 32'h80000000);
        run_random(70, -1, -1);

        // Every register at zero, largest set point, descent law
        load_profile(1'b0, 31'd0, 40'd0, 24'd0, 24'd0, 24'd0, 24'd0, 32'h7fffffff);
        run_random(70, -1, -1);

        // Back to a realistic descent; the tail runs with no idling
        load_profile(1'b0, 31'd866816000, 40'd700000000, 24'd40000, 24'd30000,
                     24'h004000, 24'h000800, 32'hffff0000);
        run_random(90, -1, -1);
        calm = 1'b1;
        run_random(100, -1, -1);

        s_axis_tvalid <= 1'b0;
        wait_drained();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_count == 0 && pending_cmds.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
